>>> src/gcrde_pkg.sv
// gcrde_pkg: shared types, constants and table functions of the GCR track encoder
// no dependencies; used by every module under src
`default_nettype none

package gcrde_pkg;

  localparam int MaxFillBytes = 64;
  localparam int QueueDepth   = 4;
  localparam int TrackW       = 6;
  localparam int CountW       = 13;

  // configuration register indexes
  localparam logic [1:0] RegTrack    = 2'd0;
  localparam logic [1:0] RegIdFirst  = 2'd1;
  localparam logic [1:0] RegIdSecond = 2'd2;

  // sector error codes
  localparam logic [7:0] ErrHdrMark  = 8'd2;
  localparam logic [7:0] ErrSync     = 8'd3;
  localparam logic [7:0] ErrDataMark = 8'd4;
  localparam logic [7:0] ErrDataChk  = 8'd5;
  localparam logic [7:0] ErrHdrChk   = 8'd9;
  localparam logic [7:0] ErrDiskId   = 8'd11;

  localparam logic [7:0] SyncByte = 8'hFF;
  localparam logic [7:0] GapByte  = 8'h55;
  localparam logic [7:0] HdrMark  = 8'h08;
  localparam logic [7:0] DataMark = 8'h07;
  localparam logic [7:0] HdrPad   = 8'h0F;
  localparam logic [7:0] IdKeyA   = 8'h55;
  localparam logic [7:0] IdKeyB   = 8'hAA;

  localparam int SyncLen = 5;
  localparam int HdrLen  = 8;
  localparam int GapLen  = 9;
  localparam int ZeroLen = 2;

  typedef enum logic [0:0] {
    JOB_DATA,
    JOB_FILL
  } job_kind_t;

  typedef struct packed {
    job_kind_t  kind;
    logic       first;
    logic       sec_end;
    logic [7:0] data;
    logic [7:0] chk;
    logic [7:0] err;
    logic [4:0] sector;
  } job_t;

  typedef struct packed {
    logic [TrackW-1:0] track;
    logic [7:0]        id_first;
    logic [7:0]        id_second;
  } cfg_t;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_SYNC1,
    PH_HDR,
    PH_GAP1,
    PH_SYNC2,
    PH_MARK,
    PH_DATA,
    PH_CHK,
    PH_ZERO,
    PH_RGAP,
    PH_FILL
  } phase_t;

  function automatic logic [1:0] region_of(input logic [TrackW-1:0] t);
    logic [1:0] r;
    if (t < TrackW'(17)) r = 2'd0;
    else if (t < TrackW'(24)) r = 2'd1;
    else if (t < TrackW'(30)) r = 2'd2;
    else r = 2'd3;
    return r;
  endfunction

  function automatic logic [4:0] reg_secs(input logic [1:0] r);
    logic [4:0] v;
    unique case (r)
      2'd0: v = 5'd21;
      2'd1: v = 5'd19;
      2'd2: v = 5'd18;
      default: v = 5'd17;
    endcase
    return v;
  endfunction

  function automatic logic [4:0] reg_gap(input logic [1:0] r);
    logic [4:0] v;
    unique case (r)
      2'd0: v = 5'd9;
      2'd1: v = 5'd19;
      2'd2: v = 5'd13;
      default: v = 5'd10;
    endcase
    return v;
  endfunction

  function automatic logic [CountW-1:0] reg_len(input logic [1:0] r);
    logic [CountW-1:0] v;
    unique case (r)
      2'd0: v = 13'h1E00;
      2'd1: v = 13'h1BE0;
      2'd2: v = 13'h1A00;
      default: v = 13'h1860;
    endcase
    return v;
  endfunction

  function automatic logic [4:0] nib_code(input logic [3:0] n);
    logic [4:0] c;
    unique case (n)
      4'h0: c = 5'h0A;
      4'h1: c = 5'h0B;
      4'h2: c = 5'h12;
      4'h3: c = 5'h13;
      4'h4: c = 5'h0E;
      4'h5: c = 5'h0F;
      4'h6: c = 5'h16;
      4'h7: c = 5'h17;
      4'h8: c = 5'h09;
      4'h9: c = 5'h19;
      4'hA: c = 5'h1A;
      4'hB: c = 5'h1B;
      4'hC: c = 5'h0D;
      4'hD: c = 5'h1D;
      4'hE: c = 5'h1E;
      default: c = 5'h15;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] hdr_byte(input logic [2:0] idx, input logic [4:0] s,
                                          input logic [7:0] trk1, input logic [7:0] id2,
                                          input logic [7:0] id1, input logic [7:0] err);
    logic [7:0] s8;
    logic [7:0] chk;
    logic [7:0] v;
    s8  = {3'b000, s};
    chk = s8 ^ trk1 ^ id2 ^ id1;
    unique case (idx)
      3'd0: v = (err == ErrHdrMark) ? 8'h00 : HdrMark;
      3'd1: v = (err == ErrHdrChk) ? ~chk : chk;
      3'd2: v = s8;
      3'd3: v = trk1;
      3'd4: v = (err == ErrDiskId) ? (id2 ^ ~(s8 + IdKeyA)) : id2;
      3'd5: v = (err == ErrDiskId) ? (id1 ^ ~(s8 + IdKeyB)) : id1;
      default: v = HdrPad;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

>>> src/gcrde_front.sv
// gcrde_front: accepts input beats, tracks sector position and checksum, builds jobs
// depends on gcrde_pkg
`default_nettype none

module gcrde_front (
  input  logic              clk,
  input  logic              rst,
  input  gcrde_pkg::cfg_t   cfg,
  input  logic              push,
  input  logic              cmd,
  input  logic [7:0]        data_byte,
  input  logic [7:0]        sector_error,
  input  logic              q_full,
  output logic              enq,
  output gcrde_pkg::job_t   job
);

  logic [7:0] byte_in_sector;
  logic [4:0] sector_index;
  logic [7:0] data_checksum;
  logic [7:0] latched_error;

  logic       accept;
  logic       drop;
  logic       first;
  logic       sec_end;
  logic [7:0] err_cur;
  logic [7:0] chk_new;

  always_comb begin
    accept  = push && !q_full;
    drop    = !cmd && (sector_index >= gcrde_pkg::reg_secs(gcrde_pkg::region_of(cfg.track)));
    enq     = accept && !drop;
    first   = (byte_in_sector == 8'd0);
    sec_end = (byte_in_sector == 8'hFF);
    err_cur = first ? sector_error : latched_error;
    chk_new = (first ? 8'h00 : data_checksum) ^ data_byte;

    job.kind    = cmd ? gcrde_pkg::JOB_FILL : gcrde_pkg::JOB_DATA;
    job.first   = first;
    job.sec_end = sec_end;
    job.data    = data_byte;
    job.chk     = chk_new;
    job.err     = err_cur;
    job.sector  = sector_index;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_in_sector <= '0;
      sector_index   <= '0;
      data_checksum  <= '0;
      latched_error  <= '0;
    end else if (accept) begin
      if (cmd) begin
        byte_in_sector <= '0;
        sector_index   <= '0;
        data_checksum  <= '0;
        latched_error  <= '0;
      end else if (!drop) begin
        latched_error  <= err_cur;
        data_checksum  <= sec_end ? 8'h00 : chk_new;
        byte_in_sector <= byte_in_sector + 8'd1;
        if (sec_end) begin
          sector_index <= sector_index + 5'd1;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> src/gcrde_queue.sv
// gcrde_queue: short job queue between the front and the back end
// depends on gcrde_pkg
`default_nettype none

module gcrde_queue #(
  parameter int DEPTH = gcrde_pkg::QueueDepth
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr,
  input  gcrde_pkg::job_t wr_job,
  input  logic            rd,
  output gcrde_pkg::job_t rd_job,
  output logic            full,
  output logic            q_empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = $clog2(DEPTH + 1);

  gcrde_pkg::job_t mem [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [LW-1:0]   level;
  logic            do_wr;
  logic            do_rd;

  always_comb begin
    full    = (level == LW'(DEPTH));
    q_empty = (level == '0);
    do_wr   = wr && !full;
    do_rd   = rd && !q_empty;
    rd_job  = mem[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_wr && !do_rd) begin
        level <= level + LW'(1);
      end else if (do_rd && !do_wr) begin
        level <= level - LW'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> src/gcrde_back.sv
// gcrde_back: sequences framing, gcr codes and fill bytes, packs bits, output register
// depends on gcrde_pkg; fed by gcrde_queue
`default_nettype none

module gcrde_back #(
  parameter int MAX_FILL_BYTES = gcrde_pkg::MaxFillBytes
) (
  input  logic            clk,
  input  logic            rst,
  input  gcrde_pkg::cfg_t cfg,
  input  logic            q_empty,
  input  gcrde_pkg::job_t q_job,
  output logic            q_pop,
  input  logic            pop,
  output logic            ovalid,
  output logic [7:0]      obyte,
  output logic            olast
);

  localparam int CW = ($clog2(MAX_FILL_BYTES + 1) > 5) ? $clog2(MAX_FILL_BYTES + 1) : 5;
  localparam logic [CW-1:0] FillMax = CW'(MAX_FILL_BYTES);

  gcrde_pkg::phase_t phase, phase_next;
  logic [CW-1:0]     cnt, cnt_next;
  logic              lo, lo_next;
  gcrde_pkg::job_t   cur;
  logic [6:0]        bit_buffer, bit_buffer_next;
  logic [2:0]        bit_fill, bit_fill_next;
  logic [gcrde_pkg::CountW-1:0] track_bytes_emitted, track_bytes_emitted_next;

  logic [1:0]        region;
  logic [4:0]        gap;
  logic [gcrde_pkg::CountW-1:0] tlen;
  logic [7:0]        trk1;
  logic [7:0]        sync_b;
  logic [7:0]        tok;
  logic              is_gcr;
  logic [4:0]        code;
  logic [11:0]       tot;
  logic [11:0]       sh;
  logic              emit_g;
  logic [2:0]        fill_g;
  logic [6:0]        buf_g;
  logic              fill_emit;
  logic              emit;
  logic [7:0]        byte_n;
  logic              fin_tok;
  logic              tok_done;
  logic              fin_step;
  logic              last_n;
  logic              active;
  logic              adv;
  logic              take;

  always_comb begin
    region = gcrde_pkg::region_of(cfg.track);
    gap    = gcrde_pkg::reg_gap(region);
    tlen   = gcrde_pkg::reg_len(region);
    trk1   = 8'({2'b00, cfg.track}) + 8'd1;
    sync_b = (cur.err == gcrde_pkg::ErrSync) ? 8'h00 : gcrde_pkg::SyncByte;

    is_gcr = 1'b0;
    unique case (phase)
      gcrde_pkg::PH_HDR: begin
        tok    = gcrde_pkg::hdr_byte(cnt[2:0], cur.sector, trk1, cfg.id_second,
                                     cfg.id_first, cur.err);
        is_gcr = 1'b1;
      end
      gcrde_pkg::PH_MARK: begin
        tok    = (cur.err == gcrde_pkg::ErrDataMark) ? 8'h00 : gcrde_pkg::DataMark;
        is_gcr = 1'b1;
      end
      gcrde_pkg::PH_DATA: begin
        tok    = cur.data;
        is_gcr = 1'b1;
      end
      gcrde_pkg::PH_CHK: begin
        tok    = (cur.err == gcrde_pkg::ErrDataChk) ? ~cur.chk : cur.chk;
        is_gcr = 1'b1;
      end
      gcrde_pkg::PH_ZERO: begin
        tok    = 8'h00;
        is_gcr = 1'b1;
      end
      gcrde_pkg::PH_SYNC1, gcrde_pkg::PH_SYNC2: begin
        tok = sync_b;
      end
      default: begin
        tok = gcrde_pkg::GapByte;
      end
    endcase

    // bit packer: one 5-bit code per cycle while the back end is not stalled on the output
    code   = gcrde_pkg::nib_code(lo ? tok[3:0] : tok[7:4]);
    tot    = {bit_buffer, code};
    emit_g = (bit_fill >= 3'd3);
    sh     = tot >> (bit_fill - 3'd3);
    fill_g = emit_g ? (bit_fill - 3'd3) : (bit_fill + 3'd5);
    buf_g  = tot[6:0] & ~(7'h7F << fill_g);

    fill_emit = (track_bytes_emitted < tlen) && (cnt < FillMax);

    if (phase == gcrde_pkg::PH_IDLE) emit = 1'b0;
    else if (phase == gcrde_pkg::PH_FILL) emit = fill_emit;
    else if (is_gcr) emit = emit_g;
    else emit = 1'b1;
    byte_n = is_gcr ? sh[7:0] : tok;

    fin_tok  = ((phase == gcrde_pkg::PH_DATA) && !cur.sec_end) ||
               ((phase == gcrde_pkg::PH_RGAP) && (cnt == CW'(gap) - CW'(1)));
    tok_done = !is_gcr || lo;
    if (phase == gcrde_pkg::PH_FILL) begin
      fin_step = !fill_emit;
      last_n   = (track_bytes_emitted + 13'd1 == tlen) || (cnt + CW'(1) == FillMax);
    end else begin
      fin_step = fin_tok && tok_done;
      last_n   = fin_tok && (!is_gcr || lo || (fill_g < 3'd3));
    end

    active = (phase != gcrde_pkg::PH_IDLE);
    adv    = active && (!emit || !ovalid || pop);
    take   = (!active || (adv && fin_step)) && !q_empty;
    q_pop  = take;
  end

  always_comb begin
    phase_next               = phase;
    cnt_next                 = cnt;
    lo_next                  = lo;
    bit_buffer_next          = bit_buffer;
    bit_fill_next            = bit_fill;
    track_bytes_emitted_next = track_bytes_emitted;

    if (adv) begin
      if (is_gcr) begin
        lo_next         = !lo;
        bit_buffer_next = buf_g;
        bit_fill_next   = fill_g;
      end
      if (emit) begin
        track_bytes_emitted_next = track_bytes_emitted + 13'd1;
      end
      if (fin_step) begin
        phase_next = gcrde_pkg::PH_IDLE;
        if (phase == gcrde_pkg::PH_FILL) begin
          bit_buffer_next          = '0;
          bit_fill_next            = '0;
          track_bytes_emitted_next = '0;
        end
      end else if (tok_done) begin
        cnt_next = cnt + CW'(1);
        unique case (phase)
          gcrde_pkg::PH_SYNC1: begin
            if (cnt == CW'(gcrde_pkg::SyncLen - 1)) begin
              phase_next = gcrde_pkg::PH_HDR;
              cnt_next   = '0;
            end
          end
          gcrde_pkg::PH_HDR: begin
            if (cnt == CW'(gcrde_pkg::HdrLen - 1)) begin
              phase_next = gcrde_pkg::PH_GAP1;
              cnt_next   = '0;
            end
          end
          gcrde_pkg::PH_GAP1: begin
            if (cnt == CW'(gcrde_pkg::GapLen - 1)) begin
              phase_next = gcrde_pkg::PH_SYNC2;
              cnt_next   = '0;
            end
          end
          gcrde_pkg::PH_SYNC2: begin
            if (cnt == CW'(gcrde_pkg::SyncLen - 1)) begin
              phase_next = gcrde_pkg::PH_MARK;
              cnt_next   = '0;
            end
          end
          gcrde_pkg::PH_MARK: begin
            phase_next = gcrde_pkg::PH_DATA;
            cnt_next   = '0;
          end
          gcrde_pkg::PH_DATA: begin
            phase_next = gcrde_pkg::PH_CHK;
            cnt_next   = '0;
          end
          gcrde_pkg::PH_CHK: begin
            phase_next = gcrde_pkg::PH_ZERO;
            cnt_next   = '0;
          end
          gcrde_pkg::PH_ZERO: begin
            if (cnt == CW'(gcrde_pkg::ZeroLen - 1)) begin
              phase_next = gcrde_pkg::PH_RGAP;
              cnt_next   = '0;
            end
          end
          default: begin
          end
        endcase
      end
    end

    if (take) begin
      cnt_next = '0;
      lo_next  = 1'b0;
      if (q_job.kind == gcrde_pkg::JOB_FILL) phase_next = gcrde_pkg::PH_FILL;
      else if (q_job.first) phase_next = gcrde_pkg::PH_SYNC1;
      else phase_next = gcrde_pkg::PH_DATA;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase               <= gcrde_pkg::PH_IDLE;
      cnt                 <= '0;
      lo                  <= 1'b0;
      bit_buffer          <= '0;
      bit_fill            <= '0;
      track_bytes_emitted <= '0;
      ovalid              <= 1'b0;
    end else begin
      phase               <= phase_next;
      cnt                 <= cnt_next;
      lo                  <= lo_next;
      bit_buffer          <= bit_buffer_next;
      bit_fill            <= bit_fill_next;
      track_bytes_emitted <= track_bytes_emitted_next;
      if (adv && emit) begin
        ovalid <= 1'b1;
      end else if (pop) begin
        ovalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur <= q_job;
    end
    if (adv && emit) begin
      obyte <= byte_n;
      olast <= last_n;
    end
  end

  // sectors always start on a byte boundary of the bitstream
  a_hdr_aligned: assert property (@(posedge clk) disable iff (rst)
    (phase == gcrde_pkg::PH_HDR && cnt == '0 && !lo) |-> (bit_fill == 3'd0))
    else $error("header starts with pending bits");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (phase == gcrde_pkg::PH_FILL) |-> (cnt <= FillMax))
    else $error("fill run exceeds its cap");

  a_emit_lands: assert property (@(posedge clk) disable iff (rst)
    (adv && emit) |=> ovalid)
    else $error("emitted byte lost");

  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    (take && active) |-> (adv && fin_step))
    else $error("job taken while another is running");

endmodule

`default_nettype wire

>>> src/gcr_disk_track_encoder.sv
// gcr_disk_track_encoder: top level, configuration registers, front, job queue, back end
// depends on gcrde_pkg, gcrde_front, gcrde_queue, gcrde_back
//
// channel   direction  handshake            payload
// input     in         push / full          cmd, data_byte, sector_error
// result    out        empty / pop          gcr_byte, last
// config    in         cfg_we (no wait)     cfg_index, cfg_data
//
// the back end handles one 5-bit code or one raw byte per cycle unless a byte waiting
// for pop stalls it; a data beat gives its two codes, a sector's first beat also its
// framing, its last the checksum, zeros and region gap, and an end-of-track beat fill
// bytes up to MAX_FILL_BYTES; a dropped beat never reaches the back end.
// the front takes a beat per cycle while the 4-deep job queue has room.
// rst is synchronous and clears all control state.
// pop low stalls the back end at its next output byte once the output register holds a byte.
`default_nettype none

module gcr_disk_track_encoder #(
  parameter int MAX_FILL_BYTES = gcrde_pkg::MaxFillBytes
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic       cmd,
  input  logic [7:0] data_byte,
  input  logic [7:0] sector_error,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] gcr_byte,
  output logic       last,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  gcrde_pkg::cfg_t cfg;
  gcrde_pkg::job_t enq_job;
  gcrde_pkg::job_t q_job;
  logic            enq;
  logic            q_full;
  logic            q_empty;
  logic            q_pop;
  logic            ovalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gcrde_pkg::RegTrack:    cfg.track     <= cfg_data[gcrde_pkg::TrackW-1:0];
        gcrde_pkg::RegIdFirst:  cfg.id_first  <= cfg_data;
        gcrde_pkg::RegIdSecond: cfg.id_second <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  gcrde_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .push         (push),
    .cmd          (cmd),
    .data_byte    (data_byte),
    .sector_error (sector_error),
    .q_full       (q_full),
    .enq          (enq),
    .job          (enq_job)
  );

  gcrde_queue #(
    .DEPTH (gcrde_pkg::QueueDepth)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (enq),
    .wr_job  (enq_job),
    .rd      (q_pop),
    .rd_job  (q_job),
    .full    (q_full),
    .q_empty (q_empty)
  );

  gcrde_back #(
    .MAX_FILL_BYTES (MAX_FILL_BYTES)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_empty (q_empty),
    .q_job   (q_job),
    .q_pop   (q_pop),
    .pop     (pop),
    .ovalid  (ovalid),
    .obyte   (gcr_byte),
    .olast   (last)
  );

  assign full  = q_full;
  assign empty = !ovalid;

endmodule

`default_nettype wire
